// ===== src/itda_pkg.sv =====
// Shared types and constants of the integer to decimal ASCII unit.
package itda_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int BIT_W      = $clog2(VALUE_W);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] MINUS_CHAR = 8'd45;

  typedef logic [3:0] bcd_t;

  // Per-cycle command that all digit cells receive together.
  typedef struct packed {
    logic clear;   // start a new number: all digits to zero
    logic dabble;  // one shift-and-add-3 step, one binary bit enters below
    logic shift;   // move every digit one place toward the top
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

// ===== src/integer_to_decimal_ascii_unit.sv =====
// Top level of the 64-bit integer to decimal ASCII converter.
//
// The unit takes one 64-bit number per input beat, together with a flag that
// says whether the bits are two's complement signed or unsigned, and returns
// its decimal text one character per output beat, most significant first,
// with last set on the final character. A negative signed value is preceded
// by a '-' beat; the most negative value prints as -9223372036854775808, and
// zero prints as a single '0'. The conversion runs in a chain of twenty BCD
// digit cells using shift-and-add-3: the magnitude enters the chain one bit
// per cycle. The same chain then
// shifts the digits out toward the top cell, first dropping leading zeros
// and then delivering one character per cycle while the receiver keeps
// out_ready high. Dropped zeros and digits always add up to twenty shifts.
// A number holds the unit from its acceptance while idle through the
// conversion, the zero skip and the output of its sign and digits, and
// longer while out_ready stalls an output beat. The input is taken only
// while the unit is idle, but the final character sits in an output
// register, so the next number can be accepted while that last beat still
// waits to be taken.
module integer_to_decimal_ascii_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [itda_pkg::VALUE_W-1:0]  value,
  input  logic                          signed_mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    character,
  output logic                          last
);
  import itda_pkg::*;

  state_t             state, state_next;
  logic [VALUE_W-1:0] mag;
  logic [BIT_W-1:0]   bit_cnt;
  logic [REM_W-1:0]   remaining;
  logic               sign_pending;

  cell_ctrl_t         ctrl;
  bcd_t               digits [NUM_DIGITS];
  logic               carries [NUM_DIGITS];

  logic               in_beat;
  logic               out_free;
  logic               emit_digit;
  bcd_t               top_digit;

  assign in_ready   = (state == ST_IDLE);
  assign in_beat    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign top_digit  = digits[NUM_DIGITS-1];
  // A digit leaves the top cell once any sign character has gone out.
  assign emit_digit = (state == ST_EMIT) && out_free && !sign_pending;

  // The chain of digit cells. The binary magnitude enters at the bottom
  // cell; the top cell is the most significant decimal digit.
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      itda_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (mag[VALUE_W-1]),
        .digit_in  (4'd0),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end else begin : g_rest
      itda_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carries[i-1]),
        .digit_in  (digits[i-1]),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end
  end

  // Cell commands follow the state: dabble while bits remain, shift while
  // dropping leading zeros or handing a digit to the output register.
  always_comb begin
    ctrl.clear  = in_beat;
    ctrl.dabble = (state == ST_CONV);
    ctrl.shift  = ((state == ST_SKIP) && (top_digit == 4'd0) && (remaining != REM_W'(1)))
                || emit_digit;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt == BIT_W'(VALUE_W - 1)) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if ((top_digit != 4'd0) || (remaining == REM_W'(1))) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_digit && (remaining == REM_W'(1))) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers; the handshake state above guards their use.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      sign_pending <= signed_mode && value[VALUE_W-1];
      mag          <= (signed_mode && value[VALUE_W-1]) ? (~value + 1'b1) : value;
      bit_cnt      <= '0;
      remaining    <= REM_W'(NUM_DIGITS);
    end else begin
      if (state == ST_CONV) begin
        mag     <= {mag[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
      end
      if (ctrl.shift) begin
        remaining <= remaining - 1'b1;
      end
      if ((state == ST_EMIT) && out_free && sign_pending) begin
        sign_pending <= 1'b0;
      end
    end

    if ((state == ST_EMIT) && out_free) begin
      if (sign_pending) begin
        character <= MINUS_CHAR;
        last      <= 1'b0;
      end else begin
        character <= DIGIT_BASE + {4'd0, top_digit};
        last      <= (remaining == REM_W'(1));
      end
    end
  end

endmodule

// ===== src/itda_cell.sv =====
// One BCD digit cell of the double-dabble chain.
module itda_cell (
  input  logic                clk,
  input  itda_pkg::cell_ctrl_t ctrl,
  input  logic                carry_in,
  input  itda_pkg::bcd_t      digit_in,
  output logic                carry_out,
  output itda_pkg::bcd_t      digit
);
  import itda_pkg::*;

  bcd_t adj;

  // A digit of five or more overflows when doubled, so it is corrected first.
  always_comb begin
    adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry_out = adj[3];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[2:0], carry_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

// ===== src/itda_checker.sv =====
// Port-level checks of the integer to decimal ASCII unit, with its bind.
module itda_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [itda_pkg::VALUE_W-1:0] value,
  input logic                         signed_mode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [7:0]                   character,
  input logic                         last
);
  import itda_pkg::*;

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("output beat changed while stalled");

  // The unit leaves idle when it accepts a number, so it is busy right after a beat.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // While idle, only the final character of the previous number may wait.
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || last)
    else $error("idle with an unfinished text pending");

  // A minus sign is never the end of a text.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (character == MINUS_CHAR) |-> !last)
    else $error("minus sign marked as last character");

endmodule

bind integer_to_decimal_ascii_unit itda_checker u_itda_checker (.*);

// ===== sim/integer_to_decimal_ascii_unit_tb.sv =====
// Testbench of the integer to decimal ASCII unit: directed table, random numbers, checked text.
module integer_to_decimal_ascii_unit_tb;

  import itda_pkg::*;

  localparam int RANDOM_NUMBERS = 300;
  localparam int HOLD_OFF_AFTER = 600;  // characters checked before the long stall
  localparam int HOLD_OFF_LEN   = 500;  // cycles of the long stall
  localparam int DRAIN_CYCLES   = 100;  // further cycles waited before the final queue check

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_beat_t;

  // Typed text is empty where the predictor supplies the expectation.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               signed_mode;
    string              text;
  } directed_row_t;

  logic               clk;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] value       = '0;
  logic               signed_mode = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [7:0]         character;
  logic               last;

  text_beat_t    expected_text_q[$];
  directed_row_t directed_rows[$];
  text_beat_t    oldest_beat;
  int            mismatch_count = 0;
  int            chars_checked  = 0;

  integer_to_decimal_ascii_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .signed_mode (signed_mode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .character   (character),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

  // Decimal text of one number, most significant character first.
  function automatic void predict_decimal_text(input logic [VALUE_W-1:0] raw,
                                               input logic is_signed);
    logic [VALUE_W-1:0] magnitude;
    logic [VALUE_W-1:0] remainder;
    logic               negative;
    logic [7:0]         digits[$];
    text_beat_t         beat;
    negative  = is_signed && raw[VALUE_W-1];
    // Two's complement negation wraps, so the most negative value gives 2^63.
    magnitude = negative ? (~raw + 64'd1) : raw;
    do begin
      remainder = magnitude % 64'd10;
      digits.push_front(DIGIT_BASE + remainder[7:0]);
      magnitude = magnitude / 64'd10;
    end while (magnitude != 0);
    if (negative) begin
      beat.character = MINUS_CHAR;
      beat.last      = 1'b0;
      expected_text_q.push_back(beat);
    end
    foreach (digits[i]) begin
      beat.character = digits[i];
      beat.last      = (i == digits.size() - 1);
      expected_text_q.push_back(beat);
    end
  endfunction

  // Holds valid until the beat is taken; returns at the accepting edge with valid still high.
  task automatic offer_number(input logic [VALUE_W-1:0] number, input logic is_signed,
                              input string text);
    text_beat_t beat;
    in_valid    <= 1'b1;
    value       <= number;
    signed_mode <= is_signed;
    do @(negedge clk); while (!in_ready);
    if (text.len() == 0) begin
      predict_decimal_text(number, is_signed);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        beat.character = text[i];
        beat.last      = (i == text.len() - 1);
        expected_text_q.push_back(beat);
      end
    end
    @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_number();
    logic [VALUE_W-1:0] power;
    int                 pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
      2: begin
        power = 64'd1;
        repeat ($urandom_range(0, 19)) power = power * 64'd10;
        return power + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: return ~({$urandom, $urandom} >> $urandom_range(1, VALUE_W - 1)) + 64'd1;
    endcase
  endfunction

  // Character checker: a beat counts when valid and ready are both high before the edge.
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_text_q.size() == 0) begin
        $error("character beat with nothing expected: character=%0d last=%0b",
               character, last);
        mismatch_count++;
      end else begin
        oldest_beat = expected_text_q.pop_front();
        if (character !== oldest_beat.character) begin
          $error("character: expected %0d, got %0d", oldest_beat.character, character);
          mismatch_count++;
        end
        if (last !== oldest_beat.last) begin
          $error("last: expected %0b, got %0b", oldest_beat.last, last);
          mismatch_count++;
        end
      end
      chars_checked++;
    end
  end

  // Receiver: segments of steady ready, coin-flip ready, and short stalls, plus one long hold-off.
  initial begin
    int  seg_len;
    bit  held_off;
    held_off = 1'b0;
    @(negedge rst);
    forever begin
      if (!held_off && chars_checked >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end
      case ($urandom_range(0, 2))
        0: begin
          out_ready <= 1'b1;
          repeat ($urandom_range(10, 80)) @(posedge clk);
        end
        1: begin
          seg_len = $urandom_range(1, 30);
          repeat (seg_len) begin
            out_ready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
        end
        default: begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
          out_ready <= 1'b1;
          @(posedge clk);
        end
      endcase
    end
  end

  initial begin
    int          sent;
    int          burst;
    int          gap;
    int          wait_cycles;
    logic [VALUE_W-1:0] number;

    directed_rows.push_back('{64'd0, 1'b0, "0"});
    directed_rows.push_back('{64'd0, 1'b1, "0"});
    directed_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, "18446744073709551615"});
    directed_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1"});
    directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b1, "-9223372036854775808"});
    directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b0, "9223372036854775808"});
    directed_rows.push_back('{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, "9223372036854775807"});
    directed_rows.push_back('{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, "9223372036854775807"});
    directed_rows.push_back('{64'd1, 1'b0, "1"});
    directed_rows.push_back('{64'd9, 1'b1, "9"});
    directed_rows.push_back('{64'd10, 1'b0, "10"});
    directed_rows.push_back('{64'hFFFF_FFFF_FFFF_FFF6, 1'b1, "-10"});
    directed_rows.push_back('{64'h8AC7_2304_89E7_FFFF, 1'b0, "9999999999999999999"});
    directed_rows.push_back('{64'h8AC7_2304_89E8_0000, 1'b0, "10000000000000000000"});
    directed_rows.push_back('{64'h8AC7_2304_89E8_0000, 1'b1, ""});
    directed_rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ""});
    directed_rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ""});
    directed_rows.push_back('{64'h5555_5555_5555_5555, 1'b0, ""});
    directed_rows.push_back('{64'h5555_5555_5555_5555, 1'b1, ""});
    directed_rows.push_back('{64'd1234567890, 1'b1, ""});
    directed_rows.push_back('{64'hFFFF_FFFF_B669_FD2E, 1'b1, ""});
    directed_rows.push_back('{64'h0000_0001_0000_0000, 1'b0, ""});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_number(directed_rows[i].value, directed_rows[i].signed_mode,
                   directed_rows[i].text);
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    // Bursts of back-to-back numbers with gaps long enough to land on every
    // phase of the conversion.
    sent = 0;
    while (sent < RANDOM_NUMBERS) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        number = random_number();
        offer_number(number, 1'($urandom_range(0, 1)), "");
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_text_q.size() != 0 && wait_cycles < 50000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_text_q.size() != 0) begin
      $error("%0d expected characters never arrived", expected_text_q.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
